/* rtl/core/scula_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package scula_pkg;

  // Address window of the chip and control byte fields
  localparam logic [15:0] WINDOW_LOW   = 16'hFE10;
  localparam logic [15:0] WINDOW_HIGH  = 16'hFE1F;
  localparam int unsigned MOTOR_POS    = 7;
  localparam int unsigned RS423_POS    = 6;

  // Counter widths and reset values
  localparam int unsigned CNT_W        = 12;
  localparam int unsigned TAPE_CNT_W   = 7;
  localparam logic [CNT_W-1:0] TX_CNT_RST = 12'd13;
  localparam logic [CNT_W-1:0] RX_CNT_RST = 12'd832;
  // Cassette receive divider of 64, times 13
  localparam logic [CNT_W-1:0] RX_TAPE_RELOAD = 12'd832;

  // Command codes
  localparam logic CMD_ACCESS = 1'b0;
  localparam logic CMD_TICK   = 1'b1;

  // Update codes
  localparam logic [1:0] UPD_NONE    = 2'd0;
  localparam logic [1:0] CTS_LOW     = 2'd1;
  localparam logic [1:0] CTS_HIGH    = 2'd2;
  localparam logic [1:0] CAR_LOST    = 2'd1;
  localparam logic [1:0] CAR_PRESENT = 2'd2;
  localparam logic [1:0] MOTOR_OFF   = 2'd1;
  localparam logic [1:0] MOTOR_ON    = 2'd2;

  // Access error codes
  localparam logic [1:0] ERR_NONE       = 2'd0;
  localparam logic [1:0] ERR_READ       = 2'd1;
  localparam logic [1:0] ERR_WRONG_ADDR = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] CFG_CTL_ADDR     = 2'd0;
  localparam logic [1:0] CFG_ACIA_DIVISOR = 2'd1;
  localparam logic [1:0] CFG_ACIA_PRESENT = 2'd2;
  localparam logic [1:0] CFG_TAPE_PRESENT = 2'd3;

  typedef struct packed {
    logic        command;
    logic [15:0] address;
    logic        is_read;
    logic [7:0]  write_data;
    logic        tape_rx_bit;
    logic        tape_carrier;
    logic        acia_tx_pin;
  } item_t;

  typedef struct packed {
    logic       tx_clock_pulse;
    logic       tape_tx_valid;
    logic       tape_tx_bit;
    logic       rx_clock_pulse;
    logic       rx_bit;
    logic [1:0] cts_update;
    logic [1:0] carrier_update;
    logic [1:0] motor_update;
    logic [1:0] access_error;
    logic [7:0] control_value;
  } result_t;

  // Counter reload: 13 times the divider 1,2,4,8,16,64,128,256
  function automatic logic [CNT_W-1:0] reload_val(input logic [2:0] code);
    logic [CNT_W-1:0] val;
    case (code)
      3'd0:    val = 12'd13;
      3'd1:    val = 12'd26;
      3'd2:    val = 12'd52;
      3'd3:    val = 12'd104;
      3'd4:    val = 12'd208;
      3'd5:    val = 12'd832;
      3'd6:    val = 12'd1664;
      3'd7:    val = 12'd3328;
      default: val = 12'd13;
    endcase
    return val;
  endfunction

endpackage

`default_nettype wire

/* rtl/core/scula_in_stage.sv */
`timescale 1ns / 1ps
`default_nettype none

module scula_in_stage (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire scula_pkg::item_t in_item,
  input  wire logic            take,
  output logic                 item_valid,
  output scula_pkg::item_t     item
);
  import scula_pkg::*;

  logic  valid_r;
  item_t item_r;

  // Take a new item when the stage is empty or is handing its item on
  assign in_ready   = !valid_r || take;
  assign item_valid = valid_r;
  assign item       = item_r;

  // Hold the accepted item until the core takes it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_item;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/scula_core.sv */
`timescale 1ns / 1ps
`default_nettype none

module scula_core (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_valid,
  input  wire logic [1:0]        cfg_index,
  input  wire logic [15:0]       cfg_data,
  input  wire logic              item_valid,
  input  wire scula_pkg::item_t  item,
  output logic                   take,
  input  wire logic              out_ready,
  output logic                   out_valid,
  output scula_pkg::result_t     result
);
  import scula_pkg::*;

  // Configuration registers
  logic [15:0]           ctl_addr_r;
  logic [TAPE_CNT_W-1:0] acia_div_r;
  logic                  acia_present_r;
  logic                  tape_present_r;

  // Block state
  logic [7:0]            ctrl_r,     ctrl_nxt;
  logic [CNT_W-1:0]      tx_cnt_r,   tx_cnt_nxt;
  logic [CNT_W-1:0]      rx_cnt_r,   rx_cnt_nxt;
  logic [TAPE_CNT_W-1:0] tape_cnt_r, tape_cnt_nxt;
  logic                  held_bit_r, held_bit_nxt;

  logic                  out_valid_r;
  result_t               res_r, res_nxt;

  logic                  in_window;
  logic                  tape_mode;
  logic                  new_tape_mode;
  logic [CNT_W-1:0]      tx_dec;
  logic [CNT_W-1:0]      rx_dec;
  logic [TAPE_CNT_W:0]   tape_inc;

  assign take      = item_valid && (!out_valid_r || out_ready);
  assign out_valid = out_valid_r;
  assign result    = res_r;

  assign in_window     = (item.address >= WINDOW_LOW) && (item.address <= WINDOW_HIGH);
  assign tape_mode     = !ctrl_r[RS423_POS];
  assign new_tape_mode = !item.write_data[RS423_POS];
  assign tx_dec        = tx_cnt_r - CNT_W'(1);
  assign rx_dec        = rx_cnt_r - CNT_W'(1);
  assign tape_inc      = {1'b0, tape_cnt_r} + (TAPE_CNT_W+1)'(1);

  // Apply one item to the state and build its result
  always_comb begin
    ctrl_nxt     = ctrl_r;
    tx_cnt_nxt   = tx_cnt_r;
    rx_cnt_nxt   = rx_cnt_r;
    tape_cnt_nxt = tape_cnt_r;
    held_bit_nxt = held_bit_r;
    res_nxt      = '0;
    if (item.command == CMD_ACCESS) begin
      if (in_window) begin
        if (item.is_read) begin
          res_nxt.access_error = ERR_READ;
        end else if (item.address != ctl_addr_r) begin
          res_nxt.access_error = ERR_WRONG_ADDR;
        end else begin
          ctrl_nxt   = item.write_data;
          tx_cnt_nxt = reload_val(item.write_data[2:0]);
          rx_cnt_nxt = new_tape_mode ? RX_TAPE_RELOAD : reload_val(item.write_data[5:3]);
          if (acia_present_r) begin
            res_nxt.cts_update = new_tape_mode ? CTS_LOW : CTS_HIGH;
          end
          if (tape_present_r && (ctrl_r[MOTOR_POS] != item.write_data[MOTOR_POS])) begin
            res_nxt.motor_update = item.write_data[MOTOR_POS] ? MOTOR_ON : MOTOR_OFF;
            if (acia_present_r && new_tape_mode) begin
              if (!item.write_data[MOTOR_POS]) begin
                res_nxt.carrier_update = CAR_LOST;
              end else if (item.tape_carrier) begin
                res_nxt.carrier_update = CAR_PRESENT;
              end
            end
          end
        end
      end
    end else begin
      // Transmit divider
      tx_cnt_nxt = tx_dec;
      if (tx_dec == '0) begin
        tx_cnt_nxt = reload_val(ctrl_r[2:0]);
        if (acia_present_r) begin
          res_nxt.tx_clock_pulse = 1'b1;
          if (tape_present_r && tape_mode) begin
            res_nxt.tape_tx_valid = 1'b1;
            res_nxt.tape_tx_bit   = item.acia_tx_pin;
          end
        end
      end
      // Receive divider and tape bit sampling
      rx_cnt_nxt = rx_dec;
      if (rx_dec == '0) begin
        rx_cnt_nxt = tape_mode ? RX_TAPE_RELOAD : reload_val(ctrl_r[5:3]);
        if (acia_present_r && tape_present_r && tape_mode) begin
          res_nxt.rx_clock_pulse = 1'b1;
          res_nxt.rx_bit         = held_bit_r;
          tape_cnt_nxt           = tape_inc[TAPE_CNT_W-1:0];
          if (tape_inc >= {1'b0, acia_div_r}) begin
            tape_cnt_nxt           = '0;
            held_bit_nxt           = item.tape_rx_bit;
            res_nxt.rx_bit         = item.tape_rx_bit;
            res_nxt.carrier_update = item.tape_carrier ? CAR_PRESENT : CAR_LOST;
          end
        end
      end
    end
    res_nxt.control_value = ctrl_nxt;
  end

  // Store configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_addr_r     <= WINDOW_LOW;
      acia_div_r     <= 7'd64;
      acia_present_r <= 1'b1;
      tape_present_r <= 1'b1;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_CTL_ADDR:     ctl_addr_r     <= cfg_data;
        CFG_ACIA_DIVISOR: acia_div_r     <= cfg_data[TAPE_CNT_W-1:0];
        CFG_ACIA_PRESENT: acia_present_r <= cfg_data[0];
        CFG_TAPE_PRESENT: tape_present_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Advance the state on each item taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctrl_r     <= '0;
      tx_cnt_r   <= TX_CNT_RST;
      rx_cnt_r   <= RX_CNT_RST;
      tape_cnt_r <= '0;
      held_bit_r <= 1'b0;
    end else if (take) begin
      ctrl_r     <= ctrl_nxt;
      tx_cnt_r   <= tx_cnt_nxt;
      rx_cnt_r   <= rx_cnt_nxt;
      tape_cnt_r <= tape_cnt_nxt;
      held_bit_r <= held_bit_nxt;
    end
  end

  // Hold the result until the receiver takes it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (take) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      res_r <= res_nxt;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/serial_ula_clock_and_tape_control.sv */
// Serial control chip: clock dividers and cassette control.
// Input channel (in_*): one item per transfer, either a bus access
// (in_command 0) or a fast clock tick (in_command 1). Every item gives
// exactly one result on the out_* channel: clock pulses, tape bit, CTS,
// carrier and motor updates, access error and the control byte after the item.
// Configuration channel (cfg_*): register index and data; base address,
// serial controller divisor and the two presence flags. Always ready;
// write it only while no item is in flight.
// Path: the input register captures an item at its transfer, and the result
// register loads its result when the core takes the item, which a stall on
// the result side can delay. Throughput: one item per cycle while out_ready
// stays high; the counter decrement, compare and reload sit in combinational
// logic between the two registers.
// Stall: while out_ready is low the result register holds, the input
// register fills and then in_ready drops; no item is lost.
// Reset (rst_n low, synchronous): both channels empty, control byte 0,
// transmit count 13, receive count 832, configuration to its defaults.
`timescale 1ns / 1ps
`default_nettype none

module serial_ula_clock_and_tape_control (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        in_command,
  input  wire logic [15:0] in_address,
  input  wire logic        in_is_read,
  input  wire logic [7:0]  in_write_data,
  input  wire logic        in_tape_rx_bit,
  input  wire logic        in_tape_carrier,
  input  wire logic        in_acia_tx_pin,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             out_tx_clock_pulse,
  output logic             out_tape_tx_valid,
  output logic             out_tape_tx_bit,
  output logic             out_rx_clock_pulse,
  output logic             out_rx_bit,
  output logic [1:0]       out_cts_update,
  output logic [1:0]       out_carrier_update,
  output logic [1:0]       out_motor_update,
  output logic [1:0]       out_access_error,
  output logic [7:0]       out_control_value
);
  import scula_pkg::*;

  item_t   in_item;
  item_t   item;
  logic    item_valid;
  logic    take;
  result_t result;

  assign cfg_ready = 1'b1;

  // Gather the input fields
  assign in_item.command      = in_command;
  assign in_item.address      = in_address;
  assign in_item.is_read      = in_is_read;
  assign in_item.write_data   = in_write_data;
  assign in_item.tape_rx_bit  = in_tape_rx_bit;
  assign in_item.tape_carrier = in_tape_carrier;
  assign in_item.acia_tx_pin  = in_acia_tx_pin;

  scula_in_stage u_in_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_item    (in_item),
    .take       (take),
    .item_valid (item_valid),
    .item       (item)
  );

  scula_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .item_valid (item_valid),
    .item       (item),
    .take       (take),
    .out_ready  (out_ready),
    .out_valid  (out_valid),
    .result     (result)
  );

  // Spread the result over the output ports
  assign out_tx_clock_pulse = result.tx_clock_pulse;
  assign out_tape_tx_valid  = result.tape_tx_valid;
  assign out_tape_tx_bit    = result.tape_tx_bit;
  assign out_rx_clock_pulse = result.rx_clock_pulse;
  assign out_rx_bit         = result.rx_bit;
  assign out_cts_update     = result.cts_update;
  assign out_carrier_update = result.carrier_update;
  assign out_motor_update   = result.motor_update;
  assign out_access_error   = result.access_error;
  assign out_control_value  = result.control_value;

endmodule

`default_nettype wire

/* verif/serial_ula_clock_and_tape_control_tb.sv */
`timescale 1ns / 1ps

module serial_ula_clock_and_tape_control_tb;
  import scula_pkg::*;

  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned DRAIN_CYCLES = 8;

  logic        clk;
  logic        rst_n;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_data;
  logic        in_valid;
  logic        in_ready;
  logic        in_command;
  logic [15:0] in_address;
  logic        in_is_read;
  logic [7:0]  in_write_data;
  logic        in_tape_rx_bit;
  logic        in_tape_carrier;
  logic        in_acia_tx_pin;
  logic        out_valid;
  logic        out_ready;
  logic        out_tx_clock_pulse;
  logic        out_tape_tx_valid;
  logic        out_tape_tx_bit;
  logic        out_rx_clock_pulse;
  logic        out_rx_bit;
  logic [1:0]  out_cts_update;
  logic [1:0]  out_carrier_update;
  logic [1:0]  out_motor_update;
  logic [1:0]  out_access_error;
  logic [7:0]  out_control_value;

  serial_ula_clock_and_tape_control uut (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_command         (in_command),
    .in_address         (in_address),
    .in_is_read         (in_is_read),
    .in_write_data      (in_write_data),
    .in_tape_rx_bit     (in_tape_rx_bit),
    .in_tape_carrier    (in_tape_carrier),
    .in_acia_tx_pin     (in_acia_tx_pin),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_tx_clock_pulse (out_tx_clock_pulse),
    .out_tape_tx_valid  (out_tape_tx_valid),
    .out_tape_tx_bit    (out_tape_tx_bit),
    .out_rx_clock_pulse (out_rx_clock_pulse),
    .out_rx_bit         (out_rx_bit),
    .out_cts_update     (out_cts_update),
    .out_carrier_update (out_carrier_update),
    .out_motor_update   (out_motor_update),
    .out_access_error   (out_access_error),
    .out_control_value  (out_control_value)
  );

  // Predicted chip configuration
  logic [15:0] ctl_addr;
  logic [6:0]  acia_div;
  logic        acia_on;
  logic        tape_on;

  // Predicted chip state
  logic [7:0]  ctrl_byte;
  logic [11:0] tx_cnt;
  logic [11:0] rx_cnt;
  logic [6:0]  tape_cnt;
  logic        held_bit;
  int unsigned rx_reloads;

  result_t     pending_results[$];
  int unsigned mismatch_count;
  bit          idle_on;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Divider code to tick count: 13 times 1,2,4,8,16,64,128,256
  function automatic logic [11:0] ticks_for(input logic [2:0] code);
    int unsigned shift;
    shift = (code >= 3'd5) ? int'(code) + 1 : int'(code);
    return 12'(13 << shift);
  endfunction

  function automatic logic [11:0] tx_period();
    return ticks_for(ctrl_byte[2:0]);
  endfunction

  function automatic logic [11:0] rx_period();
    return ctrl_byte[RS423_POS] ? ticks_for(ctrl_byte[5:3]) : RX_TAPE_RELOAD;
  endfunction

  // Advance the predicted chip by one item and return its result
  function automatic result_t ula_outputs(input item_t it);
    result_t    r;
    logic [7:0] old_ctrl;
    logic [7:0] bit_cnt;
    r = '0;
    if (it.command == CMD_ACCESS) begin
      if (it.address >= WINDOW_LOW && it.address <= WINDOW_HIGH) begin
        if (it.is_read) begin
          r.access_error = ERR_READ;
        end else if (it.address != ctl_addr) begin
          r.access_error = ERR_WRONG_ADDR;
        end else begin
          old_ctrl = ctrl_byte;
          ctrl_byte = it.write_data;
          tx_cnt = tx_period();
          rx_cnt = rx_period();
          if (acia_on)
            r.cts_update = it.write_data[RS423_POS] ? CTS_HIGH : CTS_LOW;
          if (tape_on && old_ctrl[MOTOR_POS] != it.write_data[MOTOR_POS]) begin
            r.motor_update = it.write_data[MOTOR_POS] ? MOTOR_ON : MOTOR_OFF;
            if (acia_on && !ctrl_byte[RS423_POS]) begin
              if (!it.write_data[MOTOR_POS])
                r.carrier_update = CAR_LOST;
              else if (it.tape_carrier)
                r.carrier_update = CAR_PRESENT;
            end
          end
        end
      end
    end else begin
      // Transmit divider
      tx_cnt = tx_cnt - 12'd1;
      if (tx_cnt == '0) begin
        tx_cnt = tx_period();
        if (acia_on) begin
          r.tx_clock_pulse = 1'b1;
          if (tape_on && !ctrl_byte[RS423_POS]) begin
            r.tape_tx_valid = 1'b1;
            r.tape_tx_bit = it.acia_tx_pin;
          end
        end
      end
      // Receive divider and tape bit latch
      rx_cnt = rx_cnt - 12'd1;
      if (rx_cnt == '0) begin
        rx_cnt = rx_period();
        rx_reloads++;
        if (acia_on && tape_on && !ctrl_byte[RS423_POS]) begin
          bit_cnt = {1'b0, tape_cnt} + 8'd1;
          if (bit_cnt >= {1'b0, acia_div}) begin
            bit_cnt = '0;
            held_bit = it.tape_rx_bit;
            r.carrier_update = it.tape_carrier ? CAR_PRESENT : CAR_LOST;
          end
          tape_cnt = bit_cnt[6:0];
          r.rx_clock_pulse = 1'b1;
          r.rx_bit = held_bit;
        end
      end
    end
    r.control_value = ctrl_byte;
    return r;
  endfunction

  function automatic int unsigned pick_gap();
    return idle_on ? $urandom_range(0, 11) : 0;
  endfunction

  function automatic item_t make_access(input logic [15:0] addr, input logic rd,
                                        input logic [7:0] data, input logic carrier);
    item_t it;
    it.command = CMD_ACCESS;
    it.address = addr;
    it.is_read = rd;
    it.write_data = data;
    it.tape_rx_bit = 1'($urandom_range(0, 1));
    it.tape_carrier = carrier;
    it.acia_tx_pin = 1'($urandom_range(0, 1));
    return it;
  endfunction

  function automatic item_t make_tick(input logic rx_bit, input logic carrier,
                                      input logic pin);
    item_t it;
    it.command = CMD_TICK;
    it.address = 16'($urandom);
    it.is_read = 1'($urandom_range(0, 1));
    it.write_data = 8'($urandom);
    it.tape_rx_bit = rx_bit;
    it.tape_carrier = carrier;
    it.acia_tx_pin = pin;
    return it;
  endfunction

  function automatic void check_field(input string field, input logic [7:0] want,
                                      input logic [7:0] got);
    if (want !== got) begin
      $display("%0t %s: expected %0h actual %0h", $time, field, want, got);
      mismatch_count++;
    end
  endfunction

  // Hold off for a random gap, then present one item until its transfer
  task automatic send_item(input item_t it);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_command      <= it.command;
    in_address      <= it.address;
    in_is_read      <= it.is_read;
    in_write_data   <= it.write_data;
    in_tape_rx_bit  <= it.tape_rx_bit;
    in_tape_carrier <= it.tape_carrier;
    in_acia_tx_pin  <= it.acia_tx_pin;
    do @(posedge clk); while (!in_ready);
    pending_results.push_back(ula_outputs(it));
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Present one register write; cfg_valid stays high for the caller to drop
  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_CTL_ADDR:     ctl_addr = val;
      CFG_ACIA_DIVISOR: acia_div = val[6:0];
      CFG_ACIA_PRESENT: acia_on = val[0];
      CFG_TAPE_PRESENT: tape_on = val[0];
      default: ;
    endcase
  endtask

  // Reprogram all registers once the chip is idle; junk in unused data bits
  task automatic apply_config(input logic [15:0] base, input logic [6:0] div,
                              input logic acia, input logic tape);
    wait_drained();
    write_reg(CFG_CTL_ADDR, base);
    write_reg(CFG_ACIA_DIVISOR, {9'($urandom), div});
    write_reg(CFG_ACIA_PRESENT, {15'($urandom), acia});
    write_reg(CFG_TAPE_PRESENT, {15'($urandom), tape});
    cfg_valid <= 1'b0;
  endtask

  task automatic reset_dut();
    rst_n           <= 1'b0;
    in_valid        <= 1'b0;
    in_command      <= CMD_ACCESS;
    in_address      <= '0;
    in_is_read      <= 1'b0;
    in_write_data   <= '0;
    in_tape_rx_bit  <= 1'b0;
    in_tape_carrier <= 1'b0;
    in_acia_tx_pin  <= 1'b0;
    cfg_valid       <= 1'b0;
    cfg_index       <= CFG_CTL_ADDR;
    cfg_data        <= '0;
    ctl_addr   = WINDOW_LOW;
    acia_div   = 7'd64;
    acia_on    = 1'b1;
    tape_on    = 1'b1;
    ctrl_byte  = '0;
    tx_cnt     = TX_CNT_RST;
    rx_cnt     = RX_CNT_RST;
    tape_cnt   = '0;
    held_bit   = 1'b0;
    rx_reloads = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
  endtask

  // Window edges, bad accesses, motor and mode changes, one transmit period
  task automatic test_directed();
    int unsigned i;
    idle_on = 1'b1;
    send_item(make_tick(1'b0, 1'b0, 1'b1));
    send_item(make_access(WINDOW_LOW, 1'b1, 8'hA5, 1'b0));
    send_item(make_access(WINDOW_HIGH, 1'b1, 8'h5A, 1'b1));
    send_item(make_access(WINDOW_LOW + 16'd1, 1'b0, 8'hFF, 1'b1));
    send_item(make_access(WINDOW_LOW - 16'd1, 1'b0, 8'hFF, 1'b1));
    send_item(make_access(WINDOW_HIGH + 16'd1, 1'b1, 8'hFF, 1'b1));
    send_item(make_access(16'h0000, 1'b0, 8'h80, 1'b1));
    send_item(make_access(16'hFFFF, 1'b1, 8'h80, 1'b1));
    // cassette, motor on with carrier, fastest transmit clock
    send_item(make_access(ctl_addr, 1'b0, 8'h80, 1'b1));
    for (i = 0; i < 13; i++)
      send_item(make_tick(1'b1, 1'b1, ~i[0]));
    send_item(make_access(ctl_addr, 1'b0, 8'h00, 1'b1));
    send_item(make_access(ctl_addr, 1'b0, 8'h80, 1'b0));
    send_item(make_access(ctl_addr, 1'b0, 8'hFF, 1'b1));
    send_item(make_access(ctl_addr, 1'b0, 8'h47, 1'b1));
    send_item(make_tick(1'b1, 1'b1, 1'b1));
  endtask

  // Mixed ticks and bus accesses, biased toward control writes with short dividers
  task automatic test_random_mix(input int unsigned count);
    item_t       it;
    int unsigned k;
    int unsigned sel;
    for (k = 0; k < count; k++) begin
      if (k % 64 == 0)
        idle_on = ($urandom_range(0, 3) != 0);
      it = make_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                     1'($urandom_range(0, 1)));
      sel = $urandom_range(0, 99);
      if (sel >= 55) begin
        it.command = CMD_ACCESS;
        it.is_read = ($urandom_range(0, 4) == 0);
        if (sel < 75)
          it.address = ctl_addr;
        else if (sel < 90)
          it.address = WINDOW_LOW + 16'($urandom_range(0, 15));
        if ($urandom_range(0, 3) != 0) begin
          it.write_data[2:0] = 3'($urandom_range(0, 2));
          it.write_data[5:3] = 3'($urandom_range(0, 2));
        end
      end
      send_item(it);
    end
  endtask

  // Cassette receive: run ticks through a number of receive divider periods
  task automatic test_tape_receive(input int unsigned periods);
    int unsigned start;
    int unsigned n;
    logic [7:0]  data;
    data = {1'b1, 1'b0, 3'($urandom), 3'($urandom_range(0, 2))};
    send_item(make_access(ctl_addr, 1'b0, data, 1'b1));
    start = rx_reloads;
    n = 0;
    while (rx_reloads - start < periods) begin
      if (n % 128 == 0)
        idle_on = ($urandom_range(0, 3) == 0);
      if (n < 4 && $urandom_range(0, 1) == 0) begin
        // toggle the motor before the period runs, stay in cassette mode
        data = {~ctrl_byte[MOTOR_POS], 1'b0, ctrl_byte[5:0]};
        send_item(make_access(ctl_addr, 1'b0, data, 1'($urandom_range(0, 1))));
      end else if ($urandom_range(0, 199) == 0) begin
        send_item(make_access(WINDOW_LOW + 16'($urandom_range(0, 15)), 1'b1,
                              8'($urandom), 1'b0));
      end else begin
        send_item(make_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                            1'($urandom_range(0, 1))));
      end
      n++;
    end
  endtask

  initial begin : stimulus
    mismatch_count = 0;
    idle_on = 1'b1;
    reset_dut();

    test_directed();
    test_random_mix(160);

    apply_config(WINDOW_LOW, 7'd1, 1'b1, 1'b1);
    test_tape_receive(1);
    test_random_mix(80);

    apply_config(WINDOW_HIGH, 7'd0, 1'b1, 1'b1);
    test_random_mix(60);

    apply_config(16'hFE15, 7'd127, 1'b0, 1'b1);
    test_random_mix(60);

    apply_config(16'hFFFF, 7'd1, 1'b1, 1'b0);
    test_random_mix(60);

    apply_config(16'h0000, 7'd64, 1'b0, 1'b0);
    test_random_mix(60);

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Compare each result transfer, then stall the result side at random
  initial begin : result_check
    result_t     want;
    int unsigned stall;
    stall = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          $display("%0t result with nothing pending: expected none actual control %0h",
                   $time, out_control_value);
          mismatch_count++;
        end else begin
          want = pending_results.pop_front();
          check_field("tx_clock_pulse", 8'(want.tx_clock_pulse), 8'(out_tx_clock_pulse));
          check_field("tape_tx_valid", 8'(want.tape_tx_valid), 8'(out_tape_tx_valid));
          check_field("tape_tx_bit", 8'(want.tape_tx_bit), 8'(out_tape_tx_bit));
          check_field("rx_clock_pulse", 8'(want.rx_clock_pulse), 8'(out_rx_clock_pulse));
          check_field("rx_bit", 8'(want.rx_bit), 8'(out_rx_bit));
          check_field("cts_update", 8'(want.cts_update), 8'(out_cts_update));
          check_field("carrier_update", 8'(want.carrier_update), 8'(out_carrier_update));
          check_field("motor_update", 8'(want.motor_update), 8'(out_motor_update));
          check_field("access_error", 8'(want.access_error), 8'(out_access_error));
          check_field("control_value", want.control_value, out_control_value);
        end
        stall = pick_gap();
      end
      if (stall != 0) begin
        out_ready <= 1'b0;
        stall--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Stop the run when no channel has moved a transfer for too long
  initial begin : watchdog
    int unsigned quiet_cycles;
    quiet_cycles = 0;
    forever begin
      @(posedge clk);
      if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
          (cfg_valid && cfg_ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("%0t no transfer for %0d cycles, %0d results pending",
                 $time, quiet_cycles, pending_results.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

endmodule

/* filelist.f */
rtl/core/scula_pkg.sv
rtl/core/scula_in_stage.sv
rtl/core/scula_core.sv
rtl/core/serial_ula_clock_and_tape_control.sv
verif/serial_ula_clock_and_tape_control_tb.sv
